### rtl/tfov_pkg.sv
// Shared types and constants of the toroidal field-of-view visibility test.
package tfov_pkg;

	localparam int CW = 27;
	localparam int ATAN_LEN = 24;

	localparam logic [1:0] CFG_WORLD_SIZE    = 2'd0;
	localparam logic [1:0] CFG_SENSE_RANGE   = 2'd1;
	localparam logic [1:0] CFG_FIELD_OF_VIEW = 2'd2;

	localparam logic [15:0] WORLD_SIZE_RST    = 16'd65535;
	localparam logic [14:0] SENSE_RANGE_RST   = 15'd6554;
	localparam logic [15:0] FIELD_OF_VIEW_RST = 16'd16384;

	localparam logic [31:0] HALF_TURN = 32'h8000_0000;
	localparam logic [31:0] ROUND_HALF = 32'h0000_8000;

	localparam logic [31:0] ATAN_TURNS [ATAN_LEN] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic [31:0]          z;
		logic                 zero;
		logic                 fail;
		logic [15:0]          head;
	} cordic_t;

	function automatic logic signed [16:0] wrap_diff(input logic signed [17:0] d,
		input logic [15:0] w);
		logic signed [18:0] d2;
		logic signed [18:0] w2;
		logic signed [17:0] r;
		d2 = {d, 1'b0};
		w2 = signed'({3'b000, w});
		if (d2 > w2) begin
			r = d - signed'({2'b00, w});
		end else if (d2 < -w2) begin
			r = d + signed'({2'b00, w});
		end else begin
			r = d;
		end
		return r[16:0];
	endfunction

endpackage

### rtl/tfov_if.sv
// Valid/ready channels for observer-target pairs and visibility verdicts.
interface tfov_in_if #(parameter int IDX_BITS = 12);
	logic                valid;
	logic                ready;
	logic [IDX_BITS-1:0] observer_index;
	logic [15:0]         observer_x;
	logic [15:0]         observer_y;
	logic [15:0]         observer_heading;
	logic [IDX_BITS-1:0] target_index;
	logic [15:0]         target_x;
	logic [15:0]         target_y;

	modport source (output valid, observer_index, observer_x, observer_y, observer_heading,
		target_index, target_x, target_y, input ready);
	modport sink (input valid, observer_index, observer_x, observer_y, observer_heading,
		target_index, target_x, target_y, output ready);
endinterface

interface tfov_out_if #(parameter int IDX_BITS = 12);
	logic                valid;
	logic                ready;
	logic [IDX_BITS-1:0] seen_index;
	logic                visible;

	modport source (output valid, seen_index, visible, input ready);
	modport sink (input valid, seen_index, visible, output ready);
endinterface

### rtl/tfov_geom.sv
// Front stages: torus wrap, range tests, squared distance and CORDIC set-up.
module tfov_geom #(
	parameter int IDX_BITS = 12
) (
	input  logic                  clk,
	input  logic [2:0]            en,
	input  logic [IDX_BITS-1:0]   observer_index,
	input  logic [15:0]           observer_x,
	input  logic [15:0]           observer_y,
	input  logic [15:0]           observer_heading,
	input  logic [IDX_BITS-1:0]   target_index,
	input  logic [15:0]           target_x,
	input  logic [15:0]           target_y,
	input  logic [15:0]           world_size,
	input  logic [14:0]           sense_range,
	input  logic [29:0]           range_sq,
	output tfov_pkg::cordic_t     c_out,
	output logic [IDX_BITS-1:0]   idx_out
);
	import tfov_pkg::*;

	logic signed [17:0] dx_raw, dy_raw;
	logic signed [16:0] dx_s1, dy_s1;
	logic               self_s1;
	logic [IDX_BITS-1:0] idx_s1, idx_s2;
	logic [15:0]        head_s1, head_s2;

	logic [16:0]        adx, ady;
	logic signed [16:0] dx_s2, dy_s2;
	logic [29:0]        sqx_s2, sqy_s2;
	logic               fail_s2, zero_s2;

	logic [30:0]        sum_sq;
	logic signed [15:0] dx16, dy16;
	logic signed [CW-1:0] x0, y0;
	cordic_t            c_nxt;

	assign dx_raw = signed'({2'b00, target_x}) - signed'({2'b00, observer_x});
	assign dy_raw = signed'({2'b00, target_y}) - signed'({2'b00, observer_y});

	always_ff @(posedge clk) begin
		if (en[0]) begin
			dx_s1   <= wrap_diff(dx_raw, world_size);
			dy_s1   <= wrap_diff(dy_raw, world_size);
			self_s1 <= (observer_index == target_index);
			idx_s1  <= target_index;
			head_s1 <= observer_heading;
		end
	end

	assign adx = dx_s1[16] ? 17'(-dx_s1) : 17'(dx_s1);
	assign ady = dy_s1[16] ? 17'(-dy_s1) : 17'(dy_s1);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			fail_s2 <= self_s1 || (adx > {2'b00, sense_range}) || (ady > {2'b00, sense_range});
			zero_s2 <= (dx_s1 == '0) && (dy_s1 == '0);
			sqx_s2  <= 30'(adx[14:0]) * 30'(adx[14:0]);
			sqy_s2  <= 30'(ady[14:0]) * 30'(ady[14:0]);
			dx_s2   <= dx_s1;
			dy_s2   <= dy_s1;
			idx_s2  <= idx_s1;
			head_s2 <= head_s1;
		end
	end

	assign sum_sq = {1'b0, sqx_s2} + {1'b0, sqy_s2};
	assign dx16 = dx_s2[15:0];
	assign dy16 = dy_s2[15:0];
	assign x0 = {{(CW-24){dx16[15]}}, dx16, 8'd0};
	assign y0 = {{(CW-24){dy16[15]}}, dy16, 8'd0};

	always_comb begin
		c_nxt.fail = fail_s2 || (sum_sq > {1'b0, range_sq});
		c_nxt.zero = zero_s2;
		c_nxt.head = head_s2;
		if (dx16[15]) begin
			c_nxt.x = -x0;
			c_nxt.y = -y0;
			c_nxt.z = HALF_TURN;
		end else begin
			c_nxt.x = x0;
			c_nxt.y = y0;
			c_nxt.z = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			c_out   <= c_nxt;
			idx_out <= idx_s2;
		end
	end

endmodule

### rtl/tfov_cordic_stage.sv
// One vectoring CORDIC micro-rotation with its pipeline register.
module tfov_cordic_stage #(
	parameter int IDX_BITS = 12,
	parameter int SHIFT = 0
) (
	input  logic                clk,
	input  logic                en,
	input  tfov_pkg::cordic_t   c_in,
	input  logic [IDX_BITS-1:0] idx_in,
	output tfov_pkg::cordic_t   c_out,
	output logic [IDX_BITS-1:0] idx_out
);
	import tfov_pkg::*;

	localparam logic [31:0] ANGLE = ATAN_TURNS[SHIFT];

	logic signed [CW-1:0] xs, ys;
	cordic_t              c_nxt;

	assign xs = c_in.x >>> SHIFT;
	assign ys = c_in.y >>> SHIFT;

	always_comb begin
		c_nxt = c_in;
		if (!c_in.y[CW-1]) begin
			c_nxt.x = c_in.x + ys;
			c_nxt.y = c_in.y - xs;
			c_nxt.z = c_in.z + ANGLE;
		end else begin
			c_nxt.x = c_in.x - ys;
			c_nxt.y = c_in.y + xs;
			c_nxt.z = c_in.z - ANGLE;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_out   <= c_nxt;
			idx_out <= idx_in;
		end
	end

endmodule

### rtl/tfov_verdict.sv
// Output stage: bearing rounding, relative angle and field-of-view verdict.
module tfov_verdict #(
	parameter int IDX_BITS = 12
) (
	input  logic                clk,
	input  logic                en,
	input  tfov_pkg::cordic_t   c_in,
	input  logic [IDX_BITS-1:0] idx_in,
	input  logic [15:0]         field_of_view,
	output logic [IDX_BITS-1:0] seen_index,
	output logic                visible
);
	import tfov_pkg::*;

	logic [31:0] z_rnd;
	logic [15:0] bearing;
	logic [15:0] diff;
	logic [15:0] rel;
	logic        in_view;

	assign z_rnd   = c_in.z + ROUND_HALF;
	assign bearing = c_in.zero ? 16'd0 : z_rnd[31:16];
	assign diff    = bearing - c_in.head;
	assign rel     = diff[15] ? 16'(~diff + 16'd1) : diff;
	assign in_view = {rel, 1'b0} <= {1'b0, field_of_view};

	always_ff @(posedge clk) begin
		if (en) begin
			seen_index <= idx_in;
			visible    <= !c_in.fail && in_view;
		end
	end

endmodule

### rtl/toroidal_fov_visibility_test.sv
// Top level of the toroidal range and field-of-view visibility pipeline.
// One observer-target pair enters per clock unless a stalled result has
// filled every stage. Its verdict passes three front stages (torus wrap,
// per-axis range test with squaring, squared-distance test with CORDIC
// set-up), one stage per CORDIC micro-rotation, and the output register
// that rounds the bearing and tests it against half the field of view.
// Each stage holds its own valid bit and a stage moves up whenever the next
// one is empty or moving, so bubbles close up while a verdict waits at the
// output. Configuration writes are taken at any time but only while the
// pipeline is empty are results defined; the range-squared register
// follows a sense_range write in the following cycle.
module toroidal_fov_visibility_test #(
	parameter int ROBOT_INDEX_BITS = 12,
	parameter int CORDIC_STAGES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	tfov_in_if.sink     item,
	tfov_out_if.source  result
);
	import tfov_pkg::*;

	localparam int NST = CORDIC_STAGES + 4;

	logic [15:0] world_size_q;
	logic [14:0] sense_range_q;
	logic [15:0] field_of_view_q;
	logic [29:0] range_sq_q;

	logic [NST-1:0] v_q;
	logic [NST-1:0] en;

	cordic_t               cs  [CORDIC_STAGES+1];
	logic [ROBOT_INDEX_BITS-1:0] idx [CORDIC_STAGES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			world_size_q    <= WORLD_SIZE_RST;
			sense_range_q   <= SENSE_RANGE_RST;
			field_of_view_q <= FIELD_OF_VIEW_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WORLD_SIZE:    world_size_q    <= cfg_wdata;
				CFG_SENSE_RANGE:   sense_range_q   <= cfg_wdata[14:0];
				CFG_FIELD_OF_VIEW: field_of_view_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		range_sq_q <= 30'(sense_range_q) * 30'(sense_range_q);
	end

	assign en[NST-1] = !v_q[NST-1] || result.ready;
	for (genvar k = 0; k < NST - 1; k++) begin : g_en
		assign en[k] = !v_q[k] || en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) begin
				v_q[0] <= item.valid;
			end
			for (int k = 1; k < NST; k++) begin
				if (en[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	assign item.ready   = en[0];
	assign result.valid = v_q[NST-1];

	tfov_geom #(.IDX_BITS(ROBOT_INDEX_BITS)) u_geom (
		.clk              (clk),
		.en               (en[2:0]),
		.observer_index   (item.observer_index),
		.observer_x       (item.observer_x),
		.observer_y       (item.observer_y),
		.observer_heading (item.observer_heading),
		.target_index     (item.target_index),
		.target_x         (item.target_x),
		.target_y         (item.target_y),
		.world_size       (world_size_q),
		.sense_range      (sense_range_q),
		.range_sq         (range_sq_q),
		.c_out            (cs[0]),
		.idx_out          (idx[0])
	);

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
		tfov_cordic_stage #(.IDX_BITS(ROBOT_INDEX_BITS), .SHIFT(i)) u_stage (
			.clk     (clk),
			.en      (en[3+i]),
			.c_in    (cs[i]),
			.idx_in  (idx[i]),
			.c_out   (cs[i+1]),
			.idx_out (idx[i+1])
		);
	end

	tfov_verdict #(.IDX_BITS(ROBOT_INDEX_BITS)) u_verdict (
		.clk           (clk),
		.en            (en[NST-1]),
		.c_in          (cs[CORDIC_STAGES]),
		.idx_in        (idx[CORDIC_STAGES]),
		.field_of_view (field_of_view_q),
		.seen_index    (result.seen_index),
		.visible       (result.visible)
	);

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(&v_q) && !result.ready |-> !item.ready)
		else $error("pair taken while every stage is full and stalled");

	a_transfer_enters: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> v_q[0])
		else $error("accepted pair missing from first stage");

	a_output_held: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[NST-1] && !result.ready |=> v_q[NST-1] && $stable(result.seen_index))
		else $error("waiting verdict lost");

	a_range_sq: assert property (@(posedge clk) disable iff (!arst_n)
		$stable(sense_range_q) |=>
		range_sq_q == (30'($past(sense_range_q)) * 30'($past(sense_range_q))))
		else $error("range square out of step with sense_range");

endmodule
